### rtl/mmrm_pkg.sv
// Package: types, codes and arithmetic helpers of the mouse report mailbox.
`timescale 1ns / 1ps
package mmrm_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BTN_W  = 8;
	localparam int unsigned RPT_W  = 8;

	localparam logic signed [WORD_W-1:0] WORD_SMAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] WORD_SMIN = 32'sh8000_0000;
	localparam logic signed [RPT_W-1:0]  RPT_LIM   = 8'sd127;
	localparam logic signed [RPT_W-1:0]  RPT_NLIM  = -8'sd127;

	typedef enum logic [2:0] {
		MODE_ACTIVATE = 3'd0,
		MODE_RELEASE  = 3'd1,
		MODE_PUBLISH  = 3'd2,
		MODE_PEEK     = 3'd3,
		MODE_COMPLETE = 3'd4,
		MODE_RESYNC   = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]               mode;
		logic [WORD_W-1:0]        gen_tag;
		logic [BTN_W-1:0]         button_bits;
		logic signed [WORD_W-1:0] move_x;
		logic signed [WORD_W-1:0] move_y;
		logic signed [WORD_W-1:0] move_wheel;
		logic signed [WORD_W-1:0] move_pan;
		logic [WORD_W-1:0]        ack_sequence;
		logic                     ack_is_release;
	} req_item_t;

	typedef struct packed {
		logic                     ok;
		logic [WORD_W-1:0]        gen_out;
		logic [WORD_W-1:0]        seq_out;
		logic                     release_out;
		logic [BTN_W-1:0]         buttons_out;
		logic signed [RPT_W-1:0]  report_x;
		logic signed [RPT_W-1:0]  report_y;
		logic signed [RPT_W-1:0]  report_wheel;
		logic signed [RPT_W-1:0]  report_pan;
		logic signed [WORD_W-1:0] handback_wheel;
		logic signed [WORD_W-1:0] handback_pan;
	} rsp_item_t;

	// a + b or a - b, saturated to the signed 32-bit range
	function automatic logic signed [WORD_W-1:0] sat_addsub(
		input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b,
		input logic                     sub
	);
		logic signed [WORD_W:0] bx;
		logic signed [WORD_W:0] s;
		bx = sub ? -{b[WORD_W-1], b} : {b[WORD_W-1], b};
		s  = {a[WORD_W-1], a} + bx;
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? WORD_SMIN : WORD_SMAX;
		end
		return s[WORD_W-1:0];
	endfunction

	function automatic logic signed [RPT_W-1:0] clamp127(input logic signed [WORD_W-1:0] v);
		if (v > WORD_W'(RPT_LIM)) begin
			return RPT_LIM;
		end
		if (v < 32'(signed'(RPT_NLIM))) begin
			return RPT_NLIM;
		end
		return v[RPT_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] gen_next(input logic [WORD_W-1:0] g);
		logic [WORD_W-1:0] n;
		n = g + 1'b1;
		return (n == '0) ? WORD_W'(1) : n;
	endfunction

endpackage

### rtl/mmrm_if.sv
// Interfaces: event request channel and report response channel.
`timescale 1ns / 1ps
interface mmrm_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [31:0]        gen_tag;
	logic [7:0]         button_bits;
	logic signed [31:0] move_x;
	logic signed [31:0] move_y;
	logic signed [31:0] move_wheel;
	logic signed [31:0] move_pan;
	logic [31:0]        ack_sequence;
	logic               ack_is_release;

	modport source (
		output valid, mode, gen_tag, button_bits, move_x, move_y, move_wheel,
		       move_pan, ack_sequence, ack_is_release,
		input  ready
	);
	modport sink (
		input  valid, mode, gen_tag, button_bits, move_x, move_y, move_wheel,
		       move_pan, ack_sequence, ack_is_release,
		output ready
	);
endinterface

interface mmrm_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [31:0]        gen_out;
	logic [31:0]        seq_out;
	logic               release_out;
	logic [7:0]         buttons_out;
	logic signed [7:0]  report_x;
	logic signed [7:0]  report_y;
	logic signed [7:0]  report_wheel;
	logic signed [7:0]  report_pan;
	logic signed [31:0] handback_wheel;
	logic signed [31:0] handback_pan;

	modport source (
		output valid, ok, gen_out, seq_out, release_out, buttons_out, report_x,
		       report_y, report_wheel, report_pan, handback_wheel, handback_pan,
		input  ready
	);
	modport sink (
		input  valid, ok, gen_out, seq_out, release_out, buttons_out, report_x,
		       report_y, report_wheel, report_pan, handback_wheel, handback_pan,
		output ready
	);
endinterface

### rtl/mmrm_core.sv
// Mailbox state, boot mode register and the per-event update and report logic.
`timescale 1ns / 1ps
module mmrm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               fire,
	input  mmrm_pkg::req_item_t item,
	output mmrm_pkg::rsp_item_t result
);
	import mmrm_pkg::*;

	logic                     boot_mode_q;
	logic [WORD_W-1:0]        cur_gen_q, cur_gen_d;
	logic [WORD_W-1:0]        data_seq_q, data_seq_d;
	logic [WORD_W-1:0]        rel_seq_q, rel_seq_d;
	logic signed [WORD_W-1:0] acc_x_q, acc_x_d;
	logic signed [WORD_W-1:0] acc_y_q, acc_y_d;
	logic signed [WORD_W-1:0] acc_wheel_q, acc_wheel_d;
	logic signed [WORD_W-1:0] acc_pan_q, acc_pan_d;
	logic [BTN_W-1:0]         buttons_q, buttons_d;
	logic                     dirty_q, dirty_d;
	logic                     rel_wait_q, rel_wait_d;

	logic                     sub;
	logic signed [WORD_W-1:0] nx, ny, nw, np;
	logic signed [RPT_W-1:0]  rx, ry, rw, rp;
	logic                     gen_match;
	logic                     restart;
	logic                     changed;
	logic                     acc_nz;

	// one shared saturating adder per axis: add on publish, subtract on complete
	assign sub = (item.mode == MODE_COMPLETE);
	assign nx  = sat_addsub(acc_x_q, item.move_x, sub);
	assign ny  = sat_addsub(acc_y_q, item.move_y, sub);
	assign nw  = sat_addsub(acc_wheel_q, item.move_wheel, sub);
	assign np  = sat_addsub(acc_pan_q, item.move_pan, sub);

	assign rx = clamp127(acc_x_q);
	assign ry = clamp127(acc_y_q);
	assign rw = boot_mode_q ? '0 : clamp127(acc_wheel_q);
	assign rp = boot_mode_q ? '0 : clamp127(acc_pan_q);

	assign gen_match = (item.gen_tag == cur_gen_q);
	assign changed   = (item.button_bits != buttons_q) || (item.move_x != '0) ||
	                   (item.move_y != '0) || (item.move_wheel != '0) ||
	                   (item.move_pan != '0);
	assign acc_nz    = (acc_x_q != '0) || (acc_y_q != '0) || (acc_wheel_q != '0) ||
	                   (acc_pan_q != '0);

	always_comb begin
		cur_gen_d   = cur_gen_q;
		data_seq_d  = data_seq_q;
		rel_seq_d   = rel_seq_q;
		acc_x_d     = acc_x_q;
		acc_y_d     = acc_y_q;
		acc_wheel_d = acc_wheel_q;
		acc_pan_d   = acc_pan_q;
		buttons_d   = buttons_q;
		dirty_d     = dirty_q;
		rel_wait_d  = rel_wait_q;
		restart     = 1'b0;
		result      = '0;

		case (item.mode)
			MODE_ACTIVATE: begin
				restart        = 1'b1;
				result.gen_out = gen_next(cur_gen_q);
			end
			MODE_RELEASE: begin
				restart = gen_match;
			end
			MODE_PUBLISH: begin
				if (gen_match && item.gen_tag != '0) begin
					result.ok = 1'b1;
					if (changed) begin
						buttons_d   = item.button_bits;
						acc_x_d     = nx;
						acc_y_d     = ny;
						acc_wheel_d = nw;
						acc_pan_d   = np;
						dirty_d     = 1'b1;
						data_seq_d  = data_seq_q + 1'b1;
					end
				end
			end
			MODE_PEEK: begin
				if (rel_wait_q) begin
					result.ok          = 1'b1;
					result.gen_out     = cur_gen_q;
					result.seq_out     = rel_seq_q;
					result.release_out = 1'b1;
				end else if (dirty_q) begin
					result.ok             = 1'b1;
					result.gen_out        = cur_gen_q;
					result.seq_out        = data_seq_q;
					result.buttons_out    = buttons_q;
					result.report_x       = rx;
					result.report_y       = ry;
					result.report_wheel   = rw;
					result.report_pan     = rp;
					result.handback_wheel = boot_mode_q ? acc_wheel_q : WORD_W'(rw);
					result.handback_pan   = boot_mode_q ? acc_pan_q : WORD_W'(rp);
				end
			end
			MODE_COMPLETE: begin
				if (gen_match) begin
					if (item.ack_is_release) begin
						if (item.ack_sequence == rel_seq_q) begin
							rel_wait_d = 1'b0;
						end
					end else begin
						acc_x_d     = nx;
						acc_y_d     = ny;
						acc_wheel_d = nw;
						acc_pan_d   = np;
						if (item.ack_sequence == data_seq_q) begin
							dirty_d = (nx != '0) || (ny != '0) || (nw != '0) || (np != '0);
						end else begin
							dirty_d = 1'b1;
						end
					end
				end
			end
			MODE_RESYNC: begin
				data_seq_d = data_seq_q + 1'b1;
				rel_seq_d  = rel_seq_q + 1'b1;
				rel_wait_d = 1'b1;
				dirty_d    = (buttons_q != '0) || acc_nz;
			end
			default: begin
			end
		endcase

		if (restart) begin
			cur_gen_d   = gen_next(cur_gen_q);
			acc_x_d     = '0;
			acc_y_d     = '0;
			acc_wheel_d = '0;
			acc_pan_d   = '0;
			buttons_d   = '0;
			dirty_d     = 1'b0;
			data_seq_d  = data_seq_q + 1'b1;
			rel_seq_d   = rel_seq_q + 1'b1;
			rel_wait_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_mode_q <= 1'b0;
		end else if (cfg_we) begin
			boot_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gen_q   <= '0;
			data_seq_q  <= '0;
			rel_seq_q   <= WORD_W'(1);
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_wheel_q <= '0;
			acc_pan_q   <= '0;
			buttons_q   <= '0;
			dirty_q     <= 1'b0;
			rel_wait_q  <= 1'b1;
		end else if (fire) begin
			cur_gen_q   <= cur_gen_d;
			data_seq_q  <= data_seq_d;
			rel_seq_q   <= rel_seq_d;
			acc_x_q     <= acc_x_d;
			acc_y_q     <= acc_y_d;
			acc_wheel_q <= acc_wheel_d;
			acc_pan_q   <= acc_pan_d;
			buttons_q   <= buttons_d;
			dirty_q     <= dirty_d;
			rel_wait_q  <= rel_wait_d;
		end
	end

`ifndef SYNTHESIS
	a_gen_nonzero_after_activate: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_ACTIVATE |=> cur_gen_q != '0)
		else $error("generation zero after activate");

	a_activate_schedules_release: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_ACTIVATE |=> rel_wait_q && !dirty_q && buttons_q == '0)
		else $error("activate did not schedule a clean release");

	a_release_report_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result.release_out |-> result.ok && result.buttons_out == '0 &&
			result.report_x == '0 && result.handback_wheel == '0)
		else $error("release report carries motion");

	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> result.report_x != 8'h80 && result.report_y != 8'h80 &&
			result.report_wheel != 8'h80 && result.report_pan != 8'h80)
		else $error("report axis outside +-127");
`endif

endmodule

### rtl/mouse_motion_report_mailbox.sv
// Top level of the mouse report mailbox: input register, core and result register.
`timescale 1ns / 1ps
// Usage:
//   req  : one event per transaction (activate, release, publish, peek, complete,
//          resync) with generation, buttons, motion deltas and acknowledge fields.
//   rsp  : exactly one result transaction per event, in event order.
//   cfg  : cfg_we/cfg_wdata write the boot mode bit; write only while idle.
// Path: an accepted event passes the input register, then the state update and
//   report logic into the result register, which drives rsp.
// Throughput: one event per cycle while rsp is not held; the state update is a
//   single pass of saturating adders, clamps and compares.
// Reset: arst_n clears generation, sequence and accumulators, sets the release
//   sequence to 1 with a release report pending, and clears boot mode.
// Stall: while rsp is held, the result register keeps its transaction; one more
//   event may sit in the input register, after which req.ready drops.
module mouse_motion_report_mailbox (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	mmrm_req_if.sink   req,
	mmrm_rsp_if.source rsp
);
	import mmrm_pkg::*;

	req_item_t item_s1;
	logic      valid_s1;
	rsp_item_t result;
	rsp_item_t rsp_q;
	logic      rsp_valid_q;
	logic      advance;
	logic      fire;
	logic      req_ready;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req_ready = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;
	assign req.ready = req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			item_s1 <= '{mode: req.mode, gen_tag: req.gen_tag, button_bits: req.button_bits,
				move_x: req.move_x, move_y: req.move_y, move_wheel: req.move_wheel,
				move_pan: req.move_pan, ack_sequence: req.ack_sequence,
				ack_is_release: req.ack_is_release};
		end
	end

	mmrm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = rsp_q.ok;
	assign rsp.gen_out        = rsp_q.gen_out;
	assign rsp.seq_out        = rsp_q.seq_out;
	assign rsp.release_out    = rsp_q.release_out;
	assign rsp.buttons_out    = rsp_q.buttons_out;
	assign rsp.report_x       = rsp_q.report_x;
	assign rsp.report_y       = rsp_q.report_y;
	assign rsp.report_wheel   = rsp_q.report_wheel;
	assign rsp.report_pan     = rsp_q.report_pan;
	assign rsp.handback_wheel = rsp_q.handback_wheel;
	assign rsp.handback_pan   = rsp_q.handback_pan;

endmodule

### tb/mouse_report_monitor.sv
// Monitor for the mouse report mailbox: predicts each report and compares it with the block.
`timescale 1ns / 1ps
module mouse_report_monitor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	mmrm_req_if              req,
	mmrm_rsp_if              rsp,
	output int               fail_count,
	output int               pending,
	output logic [31:0]      hint_gen,
	output logic [31:0]      hint_dseq,
	output logic [31:0]      hint_rseq,
	output logic [3:0][31:0] hint_ack
);
	import mmrm_pkg::*;

	logic                     boot;
	logic [31:0]              gen;
	logic [31:0]              dseq;
	logic [31:0]              rseq;
	logic signed [31:0]       ax, ay, aw, ap;
	logic [7:0]               btn;
	logic                     dirty;
	logic                     rel_wait;
	logic [3:0][31:0]         last_sent;
	rsp_item_t                expected_reports[$];

	assign hint_gen  = gen;
	assign hint_dseq = dseq;
	assign hint_rseq = rseq;
	assign hint_ack  = last_sent;

	initial fail_count = 0;

	function automatic logic signed [31:0] sat_word(input longint v);
		if (v > WORD_SMAX) begin
			return WORD_SMAX;
		end
		if (v < WORD_SMIN) begin
			return WORD_SMIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [7:0] clip127(input logic signed [31:0] v);
		if (v > 32'sd127) begin
			return 8'sd127;
		end
		if (v < -32'sd127) begin
			return -8'sd127;
		end
		return v[7:0];
	endfunction

	task automatic clear_mailbox();
		boot      = 1'b0;
		gen       = '0;
		dseq      = '0;
		rseq      = 32'd1;
		ax        = '0;
		ay        = '0;
		aw        = '0;
		ap        = '0;
		btn       = '0;
		dirty     = 1'b0;
		rel_wait  = 1'b1;
		last_sent = '0;
	endtask

	task automatic restart_session();
		gen      = (gen == 32'hffff_ffff) ? 32'd1 : gen + 32'd1;
		ax       = '0;
		ay       = '0;
		aw       = '0;
		ap       = '0;
		btn      = '0;
		dirty    = 1'b0;
		dseq     = dseq + 32'd1;
		rseq     = rseq + 32'd1;
		rel_wait = 1'b1;
	endtask

	task automatic mailbox_step(input req_item_t ev, output rsp_item_t r);
		r = '0;
		case (ev.mode)
			MODE_ACTIVATE: begin
				restart_session();
				r.gen_out = gen;
			end
			MODE_RELEASE: begin
				if (ev.gen_tag == gen) begin
					restart_session();
				end
			end
			MODE_PUBLISH: begin
				if (ev.gen_tag != 32'd0 && ev.gen_tag == gen) begin
					r.ok = 1'b1;
					if (btn != ev.button_bits || ev.move_x != 0 || ev.move_y != 0 ||
					    ev.move_wheel != 0 || ev.move_pan != 0) begin
						btn   = ev.button_bits;
						ax    = sat_word(longint'(ax) + longint'(ev.move_x));
						ay    = sat_word(longint'(ay) + longint'(ev.move_y));
						aw    = sat_word(longint'(aw) + longint'(ev.move_wheel));
						ap    = sat_word(longint'(ap) + longint'(ev.move_pan));
						dirty = 1'b1;
						dseq  = dseq + 32'd1;
					end
				end
			end
			MODE_PEEK: begin
				if (rel_wait) begin
					r.ok          = 1'b1;
					r.gen_out     = gen;
					r.seq_out     = rseq;
					r.release_out = 1'b1;
				end else if (dirty) begin
					r.ok             = 1'b1;
					r.gen_out        = gen;
					r.seq_out        = dseq;
					r.buttons_out    = btn;
					r.report_x       = clip127(ax);
					r.report_y       = clip127(ay);
					r.report_wheel   = boot ? 8'sd0 : clip127(aw);
					r.report_pan     = boot ? 8'sd0 : clip127(ap);
					r.handback_wheel = boot ? aw : 32'(r.report_wheel);
					r.handback_pan   = boot ? ap : 32'(r.report_pan);
					last_sent[0]     = 32'(r.report_x);
					last_sent[1]     = 32'(r.report_y);
					last_sent[2]     = r.handback_wheel;
					last_sent[3]     = r.handback_pan;
				end
			end
			MODE_COMPLETE: begin
				if (ev.gen_tag == gen) begin
					if (ev.ack_is_release) begin
						if (ev.ack_sequence == rseq) begin
							rel_wait = 1'b0;
						end
					end else begin
						ax = sat_word(longint'(ax) - longint'(ev.move_x));
						ay = sat_word(longint'(ay) - longint'(ev.move_y));
						aw = sat_word(longint'(aw) - longint'(ev.move_wheel));
						ap = sat_word(longint'(ap) - longint'(ev.move_pan));
						if (ev.ack_sequence == dseq) begin
							dirty = (ax != 0) || (ay != 0) || (aw != 0) || (ap != 0);
						end else begin
							dirty = 1'b1;
						end
					end
				end
			end
			MODE_RESYNC: begin
				dseq     = dseq + 32'd1;
				rseq     = rseq + 32'd1;
				rel_wait = 1'b1;
				dirty    = (btn != 0) || (ax != 0) || (ay != 0) || (aw != 0) || (ap != 0);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_report(input rsp_item_t want, input rsp_item_t got);
		check_field("ok", want.ok, got.ok);
		check_field("gen_out", want.gen_out, got.gen_out);
		check_field("seq_out", want.seq_out, got.seq_out);
		check_field("release_out", want.release_out, got.release_out);
		check_field("buttons_out", want.buttons_out, got.buttons_out);
		check_field("report_x", want.report_x, got.report_x);
		check_field("report_y", want.report_y, got.report_y);
		check_field("report_wheel", want.report_wheel, got.report_wheel);
		check_field("report_pan", want.report_pan, got.report_pan);
		check_field("handback_wheel", want.handback_wheel, got.handback_wheel);
		check_field("handback_pan", want.handback_pan, got.handback_pan);
	endtask

	always @(posedge clk or negedge arst_n) begin
		req_item_t ev;
		rsp_item_t want;
		rsp_item_t got;
		if (!arst_n) begin
			clear_mailbox();
			expected_reports.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				boot = cfg_wdata;
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.ok             = rsp.ok;
				got.gen_out        = rsp.gen_out;
				got.seq_out        = rsp.seq_out;
				got.release_out    = rsp.release_out;
				got.buttons_out    = rsp.buttons_out;
				got.report_x       = rsp.report_x;
				got.report_y       = rsp.report_y;
				got.report_wheel   = rsp.report_wheel;
				got.report_pan     = rsp.report_pan;
				got.handback_wheel = rsp.handback_wheel;
				got.handback_pan   = rsp.handback_pan;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual %h",
						$time, got);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					compare_report(want, got);
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				ev.mode           = req.mode;
				ev.gen_tag        = req.gen_tag;
				ev.button_bits    = req.button_bits;
				ev.move_x         = req.move_x;
				ev.move_y         = req.move_y;
				ev.move_wheel     = req.move_wheel;
				ev.move_pan       = req.move_pan;
				ev.ack_sequence   = req.ack_sequence;
				ev.ack_is_release = req.ack_is_release;
				mailbox_step(ev, want);
				expected_reports.push_back(want);
			end
			pending = expected_reports.size();
		end
	end

endmodule

### tb/tb_mouse_motion_report_mailbox.sv
// Testbench top: clock, reset, event stimulus and verdict for the mouse report mailbox.
`timescale 1ns / 1ps
module tb_mouse_motion_report_mailbox;
	import mmrm_pkg::*;

	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_wdata;
	int               src_idle;
	int               sink_idle;
	int               hold_len;
	int               fail_count;
	int               pending;
	logic [31:0]      hint_gen;
	logic [31:0]      hint_dseq;
	logic [31:0]      hint_rseq;
	logic [3:0][31:0] hint_ack;
	logic [7:0]       last_btn;

	mmrm_req_if req_ch ();
	mmrm_rsp_if rsp_ch ();

	mouse_motion_report_mailbox dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	mouse_report_monitor report_mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(fail_count),
		.pending   (pending),
		.hint_gen  (hint_gen),
		.hint_dseq (hint_dseq),
		.hint_rseq (hint_rseq),
		.hint_ack  (hint_ack)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// sink side: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (hold_len - 1) @(negedge clk);
				hold_len = 0;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= sink_idle);
			end
		end
	end

	function automatic req_item_t compose_event(input logic [2:0] m, input logic [31:0] g,
		input logic [7:0] b, input logic signed [31:0] d, input logic [31:0] s,
		input logic r);
		req_item_t e;
		e.mode           = m;
		e.gen_tag        = g;
		e.button_bits    = b;
		e.move_x         = d;
		e.move_y         = d;
		e.move_wheel     = d;
		e.move_pan       = d;
		e.ack_sequence   = s;
		e.ack_is_release = r;
		return e;
	endfunction

	function automatic logic signed [31:0] pick_delta();
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			return int'($urandom_range(600)) - 300;
		end else if (r < 60) begin
			return 0;
		end else if (r < 75) begin
			return $urandom;
		end else if (r < 85) begin
			return $urandom_range(1) ? WORD_SMAX : WORD_SMIN;
		end
		return int'($urandom_range(200000)) - 100000;
	endfunction

	function automatic req_item_t pick_event();
		req_item_t e;
		int        r;
		r                = $urandom_range(99);
		e.gen_tag        = $urandom;
		e.button_bits    = 8'($urandom);
		e.move_x         = $urandom;
		e.move_y         = $urandom;
		e.move_wheel     = $urandom;
		e.move_pan       = $urandom;
		e.ack_sequence   = $urandom;
		e.ack_is_release = 1'($urandom_range(1));
		if (r < 7) begin
			e.mode = MODE_ACTIVATE;
		end else if (r < 12) begin
			e.mode = MODE_RELEASE;
			if ($urandom_range(99) < 80) begin
				e.gen_tag = hint_gen;
			end
		end else if (r < 47) begin
			e.mode = MODE_PUBLISH;
			r      = $urandom_range(99);
			if (r < 88) begin
				e.gen_tag = hint_gen;
			end else if (r < 94) begin
				e.gen_tag = '0;
			end
			if ($urandom_range(1)) begin
				e.button_bits = last_btn;
			end
			last_btn = e.button_bits;
			if ($urandom_range(99) < 20) begin
				e.move_x     = 0;
				e.move_y     = 0;
				e.move_wheel = 0;
				e.move_pan   = 0;
			end else begin
				e.move_x     = pick_delta();
				e.move_y     = pick_delta();
				e.move_wheel = pick_delta();
				e.move_pan   = pick_delta();
			end
		end else if (r < 72) begin
			e.mode = MODE_PEEK;
		end else if (r < 94) begin
			e.mode = MODE_COMPLETE;
			if ($urandom_range(99) < 90) begin
				e.gen_tag = hint_gen;
			end
			e.ack_is_release = ($urandom_range(99) < 35);
			if (e.ack_is_release) begin
				if ($urandom_range(99) < 80) begin
					e.ack_sequence = hint_rseq;
				end
			end else begin
				if ($urandom_range(99) < 70) begin
					e.ack_sequence = hint_dseq;
				end
				if ($urandom_range(99) < 60) begin
					e.move_x     = hint_ack[0];
					e.move_y     = hint_ack[1];
					e.move_wheel = hint_ack[2];
					e.move_pan   = hint_ack[3];
				end else begin
					e.move_x     = pick_delta();
					e.move_y     = pick_delta();
					e.move_wheel = pick_delta();
					e.move_pan   = pick_delta();
				end
			end
		end else if (r < 98) begin
			e.mode = MODE_RESYNC;
		end else begin
			e.mode = $urandom_range(1) ? MODE_SPARE7 : MODE_SPARE6;
		end
		return e;
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_event(input req_item_t e);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.mode           = e.mode;
		req_ch.gen_tag        = e.gen_tag;
		req_ch.button_bits    = e.button_bits;
		req_ch.move_x         = e.move_x;
		req_ch.move_y         = e.move_y;
		req_ch.move_wheel     = e.move_wheel;
		req_ch.move_pan       = e.move_pan;
		req_ch.ack_sequence   = e.ack_sequence;
		req_ch.ack_is_release = e.ack_is_release;
		req_ch.valid          = 1'b1;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_boot(input logic v);
		req_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic run_phase(input int n, input int si, input int ki, input logic boot,
		input int hold);
		write_boot(boot);
		src_idle  = si;
		sink_idle = ki;
		hold_len  = hold;
		repeat (n) send_event(pick_event());
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.mode           = MODE_ACTIVATE;
		req_ch.gen_tag        = '0;
		req_ch.button_bits    = '0;
		req_ch.move_x         = '0;
		req_ch.move_y         = '0;
		req_ch.move_wheel     = '0;
		req_ch.move_pan       = '0;
		req_ch.ack_sequence   = '0;
		req_ch.ack_is_release = 1'b0;
		src_idle              = 26;
		sink_idle             = 78;
		hold_len              = 0;
		last_btn              = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		write_boot(1'b0);
		send_event(compose_event(MODE_PEEK, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_PUBLISH, '0, 8'h01, 5, '0, 1'b0));
		send_event(compose_event(MODE_COMPLETE, hint_gen, '0, 0, hint_rseq, 1'b1));
		send_event(compose_event(MODE_PEEK, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_ACTIVATE, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_PEEK, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_COMPLETE, hint_gen, '0, 0, hint_rseq + 1, 1'b1));
		send_event(compose_event(MODE_COMPLETE, hint_gen, '0, 0, hint_rseq, 1'b1));
		send_event(compose_event(MODE_PUBLISH, hint_gen, 8'hff, WORD_SMAX, '0, 1'b0));
		send_event(compose_event(MODE_PUBLISH, hint_gen, 8'hff, WORD_SMAX, '0, 1'b0));
		send_event(compose_event(MODE_PEEK, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_PUBLISH, hint_gen, 8'hff, WORD_SMIN, '0, 1'b0));
		send_event(compose_event(MODE_PUBLISH, hint_gen, 8'hff, WORD_SMIN, '0, 1'b0));
		send_event(compose_event(MODE_PEEK, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_COMPLETE, hint_gen, '0, WORD_SMAX, hint_dseq, 1'b0));
		send_event(compose_event(MODE_COMPLETE, hint_gen, '0, WORD_SMIN, hint_dseq, 1'b0));
		send_event(compose_event(MODE_PEEK, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_PUBLISH, hint_gen, 8'hff, 0, '0, 1'b0));
		send_event(compose_event(MODE_PUBLISH, hint_gen + 5, 8'h0f, 9, '0, 1'b0));
		send_event(compose_event(MODE_RELEASE, hint_gen + 7, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_COMPLETE, hint_gen + 3, '0, 1, hint_dseq, 1'b0));
		send_event(compose_event(MODE_RESYNC, '0, '0, 0, '0, 1'b0));
		send_event(compose_event(MODE_SPARE6, 32'hffff_ffff, 8'hff, -1, '1, 1'b1));
		send_event(compose_event(MODE_SPARE7, 32'hffff_ffff, 8'hff, -1, '1, 1'b1));
		send_event(compose_event(MODE_RELEASE, hint_gen, '0, 0, '0, 1'b0));

		run_phase(200, 26, 78, 1'b1, 0);
		run_phase(200, 78, 26, 1'b0, 0);
		run_phase(200, 0, 0, 1'b1, 80);

		req_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
